>>> hw/rtl/rrov_pkg.sv
// rrov_pkg: types, constants and atan table shared by the outline vertex core
// no dependencies
package rrov_pkg;

    localparam int TABLE_LEN = 24;
    localparam logic [31:0] HALF_PI_Q30 = 32'h6487ED51;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sh026DD3B6A;
    localparam logic signed [19:0] OUT_MAX = 20'sd131071;
    localparam logic signed [19:0] OUT_MIN = -20'sd131072;

    localparam logic [2:0] REG_WIDTH = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_RADIUS_TL = 3'd2;
    localparam logic [2:0] REG_RADIUS_TR = 3'd3;
    localparam logic [2:0] REG_RADIUS_BR = 3'd4;
    localparam logic [2:0] REG_RADIUS_BL = 3'd5;
    localparam logic [2:0] REG_CORNER_POINTS = 3'd6;

    // cordic state: x, y in q30 with headroom, z angle
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } cordic_t;

    // per-item side info that rides along the pipe
    typedef struct packed {
        logic        oor;
        logic [1:0]  quad;
        logic [15:0] radius;
        logic signed [17:0] cx;
        logic signed [17:0] cy;
    } side_t;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'h3243F6A8;
            1: t = 32'h1DAC6705;
            2: t = 32'h0FADBAFC;
            3: t = 32'h07F56EA6;
            4: t = 32'h03FEAB76;
            5: t = 32'h01FFD55B;
            6: t = 32'h00FFFAAA;
            7: t = 32'h007FFF55;
            8: t = 32'h003FFFEA;
            9: t = 32'h001FFFFD;
            10: t = 32'h000FFFFF;
            11: t = 32'h0007FFFF;
            12: t = 32'h0003FFFF;
            13: t = 32'h0001FFFF;
            14: t = 32'h0000FFFF;
            15: t = 32'h00007FFF;
            16: t = 32'h00003FFF;
            17: t = 32'h00001FFF;
            18: t = 32'h00000FFF;
            19: t = 32'h000007FF;
            20: t = 32'h000003FF;
            21: t = 32'h000001FF;
            22: t = 32'h000000FF;
            23: t = 32'h0000007F;
            default: t = 32'h0;
        endcase
        return t;
    endfunction

endpackage

>>> hw/rtl/rrov_cordic_stage.sv
// rrov_cordic_stage: one registered cordic rotation step with side info
// depends on rrov_pkg
module rrov_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid,
    input  rrov_pkg::cordic_t cin,
    input  rrov_pkg::side_t   sin,
    output logic             valid_reg,
    output rrov_pkg::cordic_t cout_reg,
    output rrov_pkg::side_t   sout_reg
);

    localparam logic signed [33:0] ATAN = $signed({2'b00, rrov_pkg::atan_q30(STEP)});

    rrov_pkg::cordic_t c_next;
    logic signed [33:0] dx;
    logic signed [33:0] dy;

    always_comb
    begin
        dx = cin.y >>> STEP;
        dy = cin.x >>> STEP;
        if (!cin.z[33])
        begin
            c_next.x = cin.x - dx;
            c_next.y = cin.y + dy;
            c_next.z = cin.z - ATAN;
        end
        else
        begin
            c_next.x = cin.x + dx;
            c_next.y = cin.y - dy;
            c_next.z = cin.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cout_reg <= c_next;
            sout_reg <= sin;
        end
    end

endmodule

>>> hw/rtl/rrov_front.sv
// rrov_front: quadrant select, centre, angle product and pipelined angle divide
// depends on rrov_pkg
module rrov_front #(
    parameter int MAX_CORNER_POINTS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid,
    input  logic [7:0]        point_index,
    input  logic [15:0]       width,
    input  logic [15:0]       height,
    input  logic [15:0]       radius_top_left,
    input  logic [15:0]       radius_top_right,
    input  logic [15:0]       radius_bottom_right,
    input  logic [15:0]       radius_bottom_left,
    input  logic [6:0]        corner_points,
    output logic              valid_reg,
    output rrov_pkg::cordic_t cord_reg,
    output rrov_pkg::side_t   side_reg
);

    localparam int CPW = $clog2(MAX_CORNER_POINTS + 1) + 1;
    localparam int DIV_STAGES = 4;
    localparam int DIV_BITS = 8;

    logic [CPW-1:0] cp;
    logic [CPW+1:0] cp4;
    logic [9:0]     idx_w;
    logic [1:0]     quad;
    logic [CPW-1:0] rem;
    logic           oor;

    always_comb
    begin
        cp = CPW'(corner_points);
        if (corner_points == 7'd0)
            cp = CPW'(1);
        if ({25'd0, corner_points} > MAX_CORNER_POINTS)
            cp = CPW'(MAX_CORNER_POINTS);
        cp4 = {cp, 2'b00};
        idx_w = {2'b00, point_index};
        oor = ({{(CPW+2){1'b0}}, idx_w} >= {10'd0, cp4});
        // index below 4*cp: quotient found by three compares
        if ({{(CPW+2){1'b0}}, idx_w} >= {10'd0, cp4} - {10'd0, 2'b00, cp})
        begin
            quad = 2'd3;
            rem = CPW'({{(CPW+2){1'b0}}, idx_w} - 3 * {10'd0, 2'b00, cp});
        end
        else if ({{(CPW+2){1'b0}}, idx_w} >= {10'd0, 1'b0, cp, 1'b0})
        begin
            quad = 2'd2;
            rem = CPW'({{(CPW+2){1'b0}}, idx_w} - {10'd0, 1'b0, cp, 1'b0});
        end
        else if ({{(CPW+2){1'b0}}, idx_w} >= {10'd0, 2'b00, cp})
        begin
            quad = 2'd1;
            rem = CPW'({{(CPW+2){1'b0}}, idx_w} - {10'd0, 2'b00, cp});
        end
        else
        begin
            quad = 2'd0;
            rem = CPW'(idx_w);
        end
    end

    // stage a: quadrant, remainder, centre
    logic            va_reg;
    logic [CPW-1:0]  cp_a_reg;
    logic [CPW-1:0]  rem_a_reg;
    rrov_pkg::side_t side_a_reg;
    logic [15:0]     r_sel;
    logic signed [17:0] cx_sel;
    logic signed [17:0] cy_sel;

    // stage b: angle product
    logic            vb_reg;
    logic [CPW-1:0]  cp_b_reg;
    logic [31+CPW:0] prod_b_reg;
    rrov_pkg::side_t side_b_reg;

    // divider stages, DIV_BITS quotient bits each
    logic            dv_reg [DIV_STAGES-1];
    logic [CPW-1:0]  dcp_reg [DIV_STAGES-1];
    logic [CPW-1:0]  dr_reg [DIV_STAGES-1];
    logic [31:0]     dw_reg [DIV_STAGES-1];
    rrov_pkg::side_t dside_reg [DIV_STAGES-1];
    logic [CPW-1:0]  dr_next [DIV_STAGES];
    logic [31:0]     dw_next [DIV_STAGES];

    always_comb
    begin
        case (quad)
            2'd0: r_sel = radius_top_right;
            2'd1: r_sel = radius_top_left;
            2'd2: r_sel = radius_bottom_left;
            default: r_sel = radius_bottom_right;
        endcase
        if (quad == 2'd0 || quad == 2'd3)
            cx_sel = $signed({2'b00, width}) - $signed({2'b00, r_sel});
        else
            cx_sel = $signed({2'b00, r_sel});
        if (quad == 2'd2 || quad == 2'd3)
            cy_sel = $signed({2'b00, height}) - $signed({2'b00, r_sel});
        else
            cy_sel = $signed({2'b00, r_sel});
    end

    // restoring steps: word shifts dividend bits out and quotient bits in
    function automatic logic [CPW+31:0] div_steps(input logic [CPW-1:0] r_in,
                                                  input logic [31:0] w_in,
                                                  input logic [CPW-1:0] d);
        logic [CPW:0]   t;
        logic [CPW-1:0] r;
        logic [31:0]    w;
        r = r_in;
        w = w_in;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            t = {r, w[31]};
            w = {w[30:0], 1'b0};
            if (t >= {1'b0, d})
            begin
                t = t - {1'b0, d};
                w[0] = 1'b1;
            end
            r = t[CPW-1:0];
        end
        return {r, w};
    endfunction

    // m < cp so the quotient fits 32 bits and the top bits start below cp
    always_comb
    begin
        {dr_next[0], dw_next[0]} = div_steps(prod_b_reg[31+CPW:32], prod_b_reg[31:0],
                                             cp_b_reg);
        for (int j = 1; j < DIV_STAGES; j++)
            {dr_next[j], dw_next[j]} = div_steps(dr_reg[j-1], dw_reg[j-1], dcp_reg[j-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            for (int j = 0; j < DIV_STAGES - 1; j++)
                dv_reg[j] <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= valid;
            vb_reg <= va_reg;
            dv_reg[0] <= vb_reg;
            for (int j = 1; j < DIV_STAGES - 1; j++)
                dv_reg[j] <= dv_reg[j-1];
            valid_reg <= dv_reg[DIV_STAGES-2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cp_a_reg <= cp;
            rem_a_reg <= rem;
            side_a_reg.oor <= oor;
            side_a_reg.quad <= quad;
            side_a_reg.radius <= r_sel;
            side_a_reg.cx <= cx_sel;
            side_a_reg.cy <= cy_sel;

            cp_b_reg <= cp_a_reg;
            prod_b_reg <= rrov_pkg::HALF_PI_Q30 * (32+CPW)'(rem_a_reg);
            side_b_reg <= side_a_reg;

            dcp_reg[0] <= cp_b_reg;
            dr_reg[0] <= dr_next[0];
            dw_reg[0] <= dw_next[0];
            dside_reg[0] <= side_b_reg;
            for (int j = 1; j < DIV_STAGES - 1; j++)
            begin
                dcp_reg[j] <= dcp_reg[j-1];
                dr_reg[j] <= dr_next[j];
                dw_reg[j] <= dw_next[j];
                dside_reg[j] <= dside_reg[j-1];
            end

            cord_reg.x <= rrov_pkg::CORDIC_GAIN_Q30;
            cord_reg.y <= '0;
            cord_reg.z <= $signed({2'b00, dw_next[DIV_STAGES-1]});
            side_reg <= dside_reg[DIV_STAGES-2];
        end
    end

endmodule

>>> hw/rtl/rrov_back.sv
// rrov_back: quadrant map, radius multiply, round, add centre, saturate
// depends on rrov_pkg
module rrov_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid,
    input  rrov_pkg::cordic_t cord,
    input  rrov_pkg::side_t   side,
    output logic              valid_reg,
    output logic signed [17:0] vx_reg,
    output logic signed [17:0] vy_reg,
    output logic              oor_reg
);

    logic signed [33:0] bc;
    logic signed [33:0] bs;

    always_comb
    begin
        case (side.quad)
            2'd0:
            begin
                bc = cord.x;
                bs = cord.y;
            end
            2'd1:
            begin
                bc = -cord.y;
                bs = cord.x;
            end
            2'd2:
            begin
                bc = -cord.x;
                bs = -cord.y;
            end
            default:
            begin
                bc = cord.y;
                bs = -cord.x;
            end
        endcase
    end

    logic              vm_reg;
    logic signed [50:0] pc_reg;
    logic signed [50:0] ps_reg;
    rrov_pkg::side_t    sm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vm_reg <= valid;
            valid_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pc_reg <= 51'($signed({1'b0, side.radius}) * bc);
            ps_reg <= 51'($signed({1'b0, side.radius}) * bs);
            sm_reg <= side;
        end
    end

    logic signed [50:0] rc;
    logic signed [50:0] rs;
    logic signed [21:0] vx_w;
    logic signed [21:0] vy_w;

    always_comb
    begin
        rc = (pc_reg + 51'sd536870912) >>> 30;
        rs = (ps_reg + 51'sd536870912) >>> 30;
        vx_w = 22'(sm_reg.cx) + rc[21:0];
        vy_w = 22'(sm_reg.cy) - rs[21:0];
    end

    function automatic logic signed [17:0] sat(input logic signed [21:0] v);
        logic signed [17:0] o;
        if (v > 22'(rrov_pkg::OUT_MAX))
            o = 18'(rrov_pkg::OUT_MAX);
        else if (v < 22'(rrov_pkg::OUT_MIN))
            o = 18'(rrov_pkg::OUT_MIN);
        else
            o = v[17:0];
        return o;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oor_reg <= sm_reg.oor;
            vx_reg <= sm_reg.oor ? 18'sd0 : sat(vx_w);
            vy_reg <= sm_reg.oor ? 18'sd0 : sat(vy_w);
        end
    end

endmodule

>>> hw/rtl/rounded_rect_outline_vertex_core.sv
// Rounded-rectangle outline vertex core. One point_index word is taken each cycle
// and one vertex word leaves each cycle, through six front stages (quadrant select,
// angle product, four divider stages of eight quotient bits each), one register per
// cordic step, and two back stages (radius multiply, round and saturate). A stall on
// a valid output word freezes the whole pipe; input stall follows it.
// Configuration words are taken at any time but must only change while idle.
module rounded_rect_outline_vertex_core #(
    parameter int MAX_CORNER_POINTS = 64,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  point_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [17:0] vertex_x,
    output logic signed [17:0] vertex_y,
    output logic        index_out_of_range,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int NIT = (ANGLE_ITERATIONS > rrov_pkg::TABLE_LEN) ?
                         rrov_pkg::TABLE_LEN : ANGLE_ITERATIONS;

    logic [15:0] width_reg, height_reg, rtl_reg, rtr_reg, rbr_reg, rbl_reg;
    logic [6:0]  cp_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= '0;
            height_reg <= '0;
            rtl_reg <= '0;
            rtr_reg <= '0;
            rbr_reg <= '0;
            rbl_reg <= '0;
            cp_reg <= 7'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rrov_pkg::REG_WIDTH: width_reg <= cfg_data;
                rrov_pkg::REG_HEIGHT: height_reg <= cfg_data;
                rrov_pkg::REG_RADIUS_TL: rtl_reg <= cfg_data;
                rrov_pkg::REG_RADIUS_TR: rtr_reg <= cfg_data;
                rrov_pkg::REG_RADIUS_BR: rbr_reg <= cfg_data;
                rrov_pkg::REG_RADIUS_BL: rbl_reg <= cfg_data;
                rrov_pkg::REG_CORNER_POINTS: cp_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // pipe advances unless a finished word is held by the consumer
    logic en;
    assign en = !(out_valid && out_stall);
    assign in_stall = !en;

    logic              v_st [NIT+1];
    rrov_pkg::cordic_t c_st [NIT+1];
    rrov_pkg::side_t   s_st [NIT+1];

    rrov_front #(.MAX_CORNER_POINTS(MAX_CORNER_POINTS)) u_front (
        .clk(clk), .rst_n(rst_n), .en(en), .valid(in_valid),
        .point_index(point_index), .width(width_reg), .height(height_reg),
        .radius_top_left(rtl_reg), .radius_top_right(rtr_reg),
        .radius_bottom_right(rbr_reg), .radius_bottom_left(rbl_reg),
        .corner_points(cp_reg),
        .valid_reg(v_st[0]), .cord_reg(c_st[0]), .side_reg(s_st[0])
    );

    for (genvar g = 0; g < NIT; g++)
    begin : g_cordic
        rrov_cordic_stage #(.STEP(g)) u_stage (
            .clk(clk), .rst_n(rst_n), .en(en), .valid(v_st[g]),
            .cin(c_st[g]), .sin(s_st[g]),
            .valid_reg(v_st[g+1]), .cout_reg(c_st[g+1]), .sout_reg(s_st[g+1])
        );
    end

    rrov_back u_back (
        .clk(clk), .rst_n(rst_n), .en(en), .valid(v_st[NIT]),
        .cord(c_st[NIT]), .side(s_st[NIT]),
        .valid_reg(out_valid), .vx_reg(vertex_x), .vy_reg(vertex_y),
        .oor_reg(index_out_of_range)
    );

    // a held word must not change under stall
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(vertex_x) && $stable(vertex_y))
        else $error("held vertex changed");

    // out of range words carry zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_out_of_range |-> vertex_x == 18'sd0 && vertex_y == 18'sd0)
        else $error("out of range vertex not zero");

    // input stall only when output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("spurious input stall");

endmodule
